FILE: design/sprs_pkg.sv
// ----------------------------------------------------------------------------
// sprs_pkg
// Shared types and constants for the scan point to ray slot block.
// ----------------------------------------------------------------------------
package sprs_pkg;

  localparam int COORD_W      = 20;
  localparam int INTEN_W      = 16;
  localparam int TOL_W        = 16;
  localparam int NUM_SLOTS    = 11;
  localparam int SLOT_W       = 4;
  localparam int FRAC_BITS_DEF = 12;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // 1/sqrt3 and sqrt3 in Q16
  localparam int K_INV_SQRT3 = 37837;
  localparam int K_SQRT3     = 113512;

  // ray slot numbers
  localparam int SLOT_NEG_ANTI   = 0;   // y = -x, x < 0
  localparam int SLOT_AXIS_POS_Y = 1;   // x = 0, y >= 0
  localparam int SLOT_STEEP_POS  = 2;   // y = x*sqrt3
  localparam int SLOT_DIAG_POS   = 3;   // y = x, x >= 0
  localparam int SLOT_SHALLOW_POS = 4;  // y = x/sqrt3
  localparam int SLOT_AXIS_POS_X = 5;   // y = 0, x >= 0
  localparam int SLOT_SHALLOW_NEG = 6;  // y = -x/sqrt3
  localparam int SLOT_ANTI_POS   = 7;   // y = -x, x >= 0
  localparam int SLOT_STEEP_NEG  = 8;   // y = -x*sqrt3
  localparam int SLOT_AXIS_NEG_Y = 9;   // x = 0, y < 0
  localparam int SLOT_DIAG_NEG   = 10;  // y = x, x < 0

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [INTEN_W-1:0] intensity;
  } slot_t;

  typedef struct packed {
    logic                 wr;
    logic                 eos;
    logic [NUM_SLOTS-1:0] hit;
  } commit_t;

endpackage

FILE: design/sprs_if.sv
// ----------------------------------------------------------------------------
// sprs_if
// Valid/ready channels for scan points in and ray slots out.
// ----------------------------------------------------------------------------
interface sprs_point_if;
  logic        valid;
  logic        ready;
  logic signed [19:0] point_x;
  logic signed [19:0] point_y;
  logic signed [19:0] point_z;
  logic [15:0] point_intensity;
  logic        end_of_scan;

  modport source (output valid, point_x, point_y, point_z, point_intensity, end_of_scan,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_intensity, end_of_scan,
                  output ready);
endinterface

interface sprs_ray_if;
  logic        valid;
  logic        ready;
  logic [3:0]  slot_index;
  logic signed [19:0] ray_x;
  logic signed [19:0] ray_y;
  logic signed [19:0] ray_z;
  logic [15:0] ray_intensity;
  logic        last_slot;

  modport source (output valid, slot_index, ray_x, ray_y, ray_z, ray_intensity, last_slot,
                  input ready);
  modport sink   (input valid, slot_index, ray_x, ray_y, ray_z, ray_intensity, last_slot,
                  output ready);
endinterface

FILE: design/sprs_band.sv
// ----------------------------------------------------------------------------
// sprs_band
// Band tests of one point against the eight lines, giving a slot hit vector.
// ----------------------------------------------------------------------------
module sprs_band
  import sprs_pkg::*;
(
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic        [TOL_W-1:0]   tol,
  output logic        [NUM_SLOTS-1:0] hit
);

  localparam int PW = COORD_W + 19;   // product width
  localparam int SW = PW - 16;        // scaled width
  localparam int DW = SW + 1;         // distance term width

  logic signed [PW-1:0] prod_inv, prod_sq;
  logic signed [SW-1:0] xi, xs;
  logic signed [DW-1:0] tol_s, d_x, d_y, d_yx, d_ypx, d_i_m, d_i_p, d_s_m, d_s_p;
  logic                 xpos, ypos;

  function automatic logic in_band(input logic signed [DW-1:0] d,
                                   input logic signed [DW-1:0] t);
    return (d >= -t) && (d <= t);
  endfunction

  always_comb begin
    // round to nearest, floor after adding half
    prod_inv = PW'(x) * PW'(K_INV_SQRT3) + PW'(32768);
    prod_sq  = PW'(x) * PW'(K_SQRT3) + PW'(32768);
    xi       = SW'(prod_inv >>> 16);
    xs       = SW'(prod_sq >>> 16);

    tol_s = $signed({{(DW-TOL_W){1'b0}}, tol});
    d_x   = DW'(x);
    d_y   = DW'(y);
    d_yx  = DW'(y) - DW'(x);
    d_ypx = DW'(y) + DW'(x);
    d_i_m = DW'(xi) - DW'(y);
    d_i_p = DW'(xi) + DW'(y);
    d_s_m = DW'(xs) - DW'(y);
    d_s_p = DW'(xs) + DW'(y);

    xpos = !x[COORD_W-1];
    ypos = !y[COORD_W-1];

    hit = '0;
    hit[SLOT_AXIS_POS_Y]  = in_band(d_x, tol_s) && ypos;
    hit[SLOT_AXIS_NEG_Y]  = in_band(d_x, tol_s) && !ypos;
    hit[SLOT_DIAG_POS]    = in_band(d_yx, tol_s) && xpos;
    hit[SLOT_DIAG_NEG]    = in_band(d_yx, tol_s) && !xpos;
    hit[SLOT_ANTI_POS]    = in_band(d_ypx, tol_s) && xpos;
    hit[SLOT_NEG_ANTI]    = in_band(d_ypx, tol_s) && !xpos;
    hit[SLOT_SHALLOW_POS] = in_band(d_i_m, tol_s) && xpos;
    hit[SLOT_SHALLOW_NEG] = in_band(d_i_p, tol_s) && xpos;
    hit[SLOT_STEEP_POS]   = in_band(d_s_m, tol_s) && xpos;
    hit[SLOT_STEEP_NEG]   = in_band(d_s_p, tol_s) && xpos;
    hit[SLOT_AXIS_POS_X]  = in_band(d_y, tol_s) && xpos;
  end

endmodule

FILE: design/sprs_slots.sv
// ----------------------------------------------------------------------------
// sprs_slots
// Working ray slots, snapshot buffer at end of scan, and the slot emitter.
// ----------------------------------------------------------------------------
module sprs_slots
  import sprs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  commit_t       commit,
  input  slot_t         point,
  output logic          busy,
  sprs_ray_if.source    out_ch
);

  slot_t             slot_r [NUM_SLOTS];
  slot_t             slot_nxt [NUM_SLOTS];
  slot_t             snap_r [NUM_SLOTS];
  logic              busy_r;
  logic [SLOT_W-1:0] cnt_r;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_idx_r;
  slot_t             out_slot_r;
  logic              out_last_r;
  logic              load;

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot_nxt[k] = commit.hit[k] ? point : slot_r[k];
    end
  end

  assign load = busy_r && (!out_valid_r || out_ch.ready);
  assign busy = busy_r;

  // working slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) slot_r[k] <= '0;
    end else if (commit.wr) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_r[k] <= commit.eos ? '0 : slot_nxt[k];
      end
    end
  end

  // snapshot taken with the last point merged in
  always_ff @(posedge clk) begin
    if (commit.wr && commit.eos) begin
      for (int k = 0; k < NUM_SLOTS; k++) snap_r[k] <= slot_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit.wr && commit.eos) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (load) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) busy_r <= 1'b0;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r <= snap_r[cnt_r];
      out_idx_r  <= cnt_r;
      out_last_r <= (cnt_r == LAST_SLOT);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.slot_index    = out_idx_r;
  assign out_ch.ray_x         = out_slot_r.x;
  assign out_ch.ray_y         = out_slot_r.y;
  assign out_ch.ray_z         = out_slot_r.z;
  assign out_ch.ray_intensity = out_slot_r.intensity;
  assign out_ch.last_slot     = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= LAST_SLOT)
    else $error("emit counter past last slot");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_idx_r == LAST_SLOT)
    else $error("last flag on wrong slot");

  a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
    (commit.wr && commit.eos) |-> !busy_r)
    else $error("end of scan committed while emitting");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (commit.wr && commit.eos) |=> busy_r && cnt_r == '0)
    else $error("emit run did not start");

endmodule

FILE: design/scan_points_to_ray_slots.sv
// ----------------------------------------------------------------------------
// scan_points_to_ray_slots
// Sorts scan points into 11 ray slots by eight line bands through the
// origin and emits the slots at the end of each scan.
// ----------------------------------------------------------------------------
//   channel   dir   handshake        carries
//   in_ch     in    valid / ready    one scan point per item
//   out_ch    out   valid / ready    one ray slot per item, 11 per scan
//   cfg_*     in    write enable     line_tolerance, no read-back
//
// one point per cycle; band tests run between the input register and the slots
// an end-of-scan point is merged, then slots are copied to a snapshot and
// cleared; the 11 slot items leave from the snapshot at up to one per cycle
// the next end-of-scan point waits in the input register until the previous
// run has left the snapshot; ordinary points keep flowing meanwhile
// synchronous active-low reset clears slots, tolerance to 0.02 m
// ----------------------------------------------------------------------------
module scan_points_to_ray_slots
  import sprs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  sprs_point_if.sink       in_ch,
  sprs_ray_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_data
);

  // 0.02 m rounded in the point format
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((2 << FRAC_BITS) + 50) / 100);

  logic [TOL_W-1:0]   tol_r;
  logic               s1_valid_r;
  logic               s1_eos_r;
  slot_t              s1_pt_r;
  logic               s1_adv;
  logic               busy;
  logic               in_acc;
  logic [NUM_SLOTS-1:0] hit;
  commit_t            commit;

  // band half width register
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_RESET;
    else if (cfg_we) tol_r <= cfg_data;
  end

  // an end-of-scan point needs the snapshot free
  assign s1_adv      = s1_valid_r && (!s1_eos_r || !busy);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_eos_r           <= in_ch.end_of_scan;
      s1_pt_r.x          <= in_ch.point_x;
      s1_pt_r.y          <= in_ch.point_y;
      s1_pt_r.z          <= in_ch.point_z;
      s1_pt_r.intensity  <= in_ch.point_intensity;
    end
  end

  sprs_band u_band (
    .x   (s1_pt_r.x),
    .y   (s1_pt_r.y),
    .tol (tol_r),
    .hit (hit)
  );

  always_comb begin
    commit.wr  = s1_adv;
    commit.eos = s1_eos_r;
    commit.hit = s1_adv ? hit : '0;
  end

  sprs_slots u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .point  (s1_pt_r),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule
